// ===== rtl/core/rgbhsv_pkg.sv =====
package rgbhsv_pkg;

    localparam int CH_W       = 8;
    localparam int HUE_W      = 13;
    localparam int STEP_BITS  = 2;
    localparam int DIV_STAGES = 5;
    localparam int QUO_W      = STEP_BITS * DIV_STAGES;
    localparam int NUM_W      = QUO_W + CH_W;

    localparam logic [HUE_W-1:0] HUE_SECTOR = 13'd960;
    localparam logic [HUE_W-1:0] HUE_FULL   = 13'd5760;
    localparam logic [CH_W-1:0]  SAT_SCALE  = 8'd255;

    // One long-division lane: partial remainder, numerator bits still to
    // bring down, quotient bits found so far, divisor.
    typedef struct packed {
        logic [CH_W-1:0]  rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
        logic [CH_W-1:0]  den;
    } lane_t;

    typedef struct packed {
        lane_t            hue_lane;
        lane_t            sat_lane;
        logic [CH_W-1:0]  max_ch;
        logic             grey;
        logic             neg;
        logic [HUE_W-1:0] base;
    } beat_t;

endpackage

// ===== rtl/core/rgbhsv_front.sv =====
module rgbhsv_front
    import rgbhsv_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            in_valid,
    input  logic [CH_W-1:0] red,
    input  logic [CH_W-1:0] green,
    input  logic [CH_W-1:0] blue,
    output logic            out_valid,
    output beat_t           out_beat
);

    logic             valid_reg;
    beat_t            beat_reg;
    beat_t            beat_next;
    logic [CH_W-1:0]  mx;
    logic [CH_W-1:0]  mn;
    logic [CH_W-1:0]  d;
    logic [CH_W-1:0]  p;
    logic [CH_W-1:0]  q;
    logic [CH_W-1:0]  mag;
    logic [HUE_W-1:0] base;
    logic [NUM_W-1:0] hue_num;
    logic [NUM_W-1:0] sat_num;

    always_comb
    begin
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx) mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        d = mx - mn;

        // Red wins ties, then green.
        priority if (mx == red)
        begin
            p    = green;
            q    = blue;
            base = (green >= blue) ? '0 : HUE_FULL;
        end
        else if (mx == green)
        begin
            p    = blue;
            q    = red;
            base = HUE_SECTOR << 1;
        end
        else
        begin
            p    = red;
            q    = green;
            base = HUE_SECTOR << 2;
        end

        mag     = (p >= q) ? (p - q) : (q - p);
        hue_num = NUM_W'(mag) * NUM_W'(HUE_SECTOR);
        sat_num = NUM_W'(d) * NUM_W'(SAT_SCALE);

        // Numerator high part is below the divisor, so it seeds the remainder.
        beat_next.hue_lane.rem = hue_num[NUM_W-1:QUO_W];
        beat_next.hue_lane.low = hue_num[QUO_W-1:0];
        beat_next.hue_lane.quo = '0;
        beat_next.hue_lane.den = d;
        beat_next.sat_lane.rem = sat_num[NUM_W-1:QUO_W];
        beat_next.sat_lane.low = sat_num[QUO_W-1:0];
        beat_next.sat_lane.quo = '0;
        beat_next.sat_lane.den = mx;
        beat_next.max_ch       = mx;
        beat_next.grey         = (d == '0);
        beat_next.neg          = (p < q);
        beat_next.base         = base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// ===== rtl/core/rgbhsv_div_stage.sv =====
module rgbhsv_div_stage
    import rgbhsv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  advance,
    input  logic  in_valid,
    input  beat_t in_beat,
    output logic  out_valid,
    output beat_t out_beat
);

    logic  valid_reg;
    beat_t beat_reg;
    beat_t beat_next;

    // Restoring division, STEP_BITS quotient bits per stage.
    function automatic lane_t div_step(lane_t l);
        lane_t         o;
        logic [CH_W:0] t;
        o = l;
        for (int k = 0; k < STEP_BITS; k++)
        begin
            t     = {o.rem, o.low[QUO_W-1]};
            o.low = {o.low[QUO_W-2:0], 1'b0};
            if (t >= {1'b0, o.den})
            begin
                o.rem = CH_W'(t - {1'b0, o.den});
                o.quo = {o.quo[QUO_W-2:0], 1'b1};
            end
            else
            begin
                o.rem = t[CH_W-1:0];
                o.quo = {o.quo[QUO_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    always_comb
    begin
        beat_next          = in_beat;
        beat_next.hue_lane = div_step(in_beat.hue_lane);
        beat_next.sat_lane = div_step(in_beat.sat_lane);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// ===== rtl/core/rgbhsv_back.sv =====
module rgbhsv_back
    import rgbhsv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             in_valid,
    input  beat_t            in_beat,
    output logic             out_valid,
    output logic [HUE_W-1:0] hue,
    output logic [CH_W-1:0]  saturation,
    output logic [CH_W-1:0]  brightness
);

    logic             valid_reg;
    logic [HUE_W-1:0] hue_reg;
    logic [HUE_W-1:0] hue_next;
    logic [CH_W-1:0]  sat_reg;
    logic [CH_W-1:0]  sat_next;
    logic [CH_W-1:0]  bright_reg;
    logic [HUE_W-1:0] quo;
    logic [HUE_W-1:0] quo_ceil;

    always_comb
    begin
        quo      = HUE_W'(in_beat.hue_lane.quo);
        quo_ceil = quo + HUE_W'(in_beat.hue_lane.rem != '0);
        // Negative offsets subtract the rounded-up magnitude.
        if (in_beat.grey)
            hue_next = '0;
        else if (in_beat.neg)
            hue_next = in_beat.base - quo_ceil;
        else
            hue_next = in_beat.base + quo;
        sat_next = (in_beat.max_ch == '0) ? '0 : in_beat.sat_lane.quo[CH_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= in_beat.max_ch;
        end
    end

    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;

endmodule

// ===== rtl/core/rgb_to_hsv_top.sv =====
// RGB to HSV pixel converter.
// Input channel: in_valid / in_stall with red, green, blue (8 bits each).
// Output channel: out_valid / out_stall with hue (1/16 degree, 0..5759),
// saturation (0..255) and brightness (largest channel).
// A beat is taken at a clock edge where valid is high and stall is low.
// Throughput: one pixel per clock unless out_stall holds the pipeline.
// Each accepted input beat passes one stage for max/min and sector select,
// five divider stages retiring two quotient bits each for the hue and
// saturation divisions, and one stage for the final hue offset.
// The whole pipeline advances together; when the output holds a beat and
// out_stall is high, every stage holds and in_stall goes high, so nothing
// is dropped or repeated. Empty stages do not collapse during a stall.
// Reset (rst_n low, asynchronous) clears all valid bits; the pipeline is
// empty and ready afterward. There is no configuration.
module rgb_to_hsv_top
    import rgbhsv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [CH_W-1:0]  red,
    input  logic [CH_W-1:0]  green,
    input  logic [CH_W-1:0]  blue,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [HUE_W-1:0] hue,
    output logic [CH_W-1:0]  saturation,
    output logic [CH_W-1:0]  brightness
);

    logic  advance;
    logic  pipe_valid [DIV_STAGES+1];
    beat_t pipe_beat  [DIV_STAGES+1];

    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    rgbhsv_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (pipe_valid[0]),
        .out_beat  (pipe_beat[0])
    );

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        rgbhsv_div_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (pipe_valid[i]),
            .in_beat   (pipe_beat[i]),
            .out_valid (pipe_valid[i+1]),
            .out_beat  (pipe_beat[i+1])
        );
    end

    rgbhsv_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (pipe_valid[DIV_STAGES]),
        .in_beat    (pipe_beat[DIV_STAGES]),
        .out_valid  (out_valid),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

endmodule
